// ===== src/spectral_fundamental_picker_assert.svh =====
// Assertion macros shared by the verification code of the spectral fundamental picker.
// No dependencies; included by the checker file.
`ifndef SPECTRAL_FUNDAMENTAL_PICKER_ASSERT_SVH
`define SPECTRAL_FUNDAMENTAL_PICKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFP_ASSERT_IMP(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFP_ASSERT_NXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sfp_pkg.sv =====
// Package of the spectral fundamental picker: widths, register codes, reset values
// and the command and status types between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package sfp_pkg;

	localparam int unsigned MAX_BINS = 16384;

	localparam int BIN_W     = 15;
	localparam int RATE_W    = 18;
	localparam int POW_W     = 32;
	localparam int FREQ_W    = 21;
	localparam int FUND_W    = 18;
	localparam int OT_W      = 2;
	localparam int SHIFT_W   = 3;
	localparam int NOISE_W   = 46;
	localparam int TOL_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	localparam int PROD_W    = RATE_W + FUND_W;
	localparam int LIMIT_W   = POW_W + BIN_W;
	localparam int SCALED_W  = FUND_W + (1 << SHIFT_W) - 1;
	localparam int DIV_STEPS = PROD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int RECIP_W    = 20;
	localparam int DIV5_SHIFT = 22;
	localparam logic [RECIP_W-1:0] DIV5_RECIP = 20'd838861;

	localparam logic [TOL_W-1:0]   TOL_MIN     = 16'd16;
	localparam logic [OT_W-1:0]    OT_MAX      = 2'd3;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd1;

	localparam logic [BIN_W-1:0]  BIN_COUNT_RESET   = 15'd4096;
	localparam logic [RATE_W-1:0] SAMPLE_RATE_RESET = 18'd48000;
	localparam logic [POW_W-1:0]  PEAK_THR_RESET    = 32'd4295;
	localparam logic [POW_W-1:0]  NOISE_THR_RESET   = 32'd4295;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BIN_COUNT   = 2'd0,
		CFG_SAMPLE_RATE = 2'd1,
		CFG_PEAK_THR    = 2'd2,
		CFG_NOISE_THR   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic accept;
		logic tol_load;
		logic fin_mul;
		logic fin_cmp;
		logic div_step;
		logic out_load;
	} sfp_cmd_t;

	typedef struct packed {
		logic fund_change;
		logic last;
	} sfp_status_t;

endpackage

// ===== src/spectral_fundamental_picker.sv =====
// Spectral fundamental picker: a bin stream goes in, each finished spectrum gives one
// pitch transaction out. A bin is taken every cycle while the spectrum streams; a bin that
// sets or refines the fundamental stalls the input while the octave tolerance is reloaded,
// at most four times a spectrum. After the last bin come the final multiplies, the noise
// compare and a 36-step bit-serial division by the bin count, then a load into the result
// register, which waits while an earlier result is still stalled.
// Configuration writes are always ready and take effect on the next cycle.
// Depends on sfp_pkg, sfp_ctrl and sfp_datapath.
`timescale 1ns / 1ps

module spectral_fundamental_picker
	import sfp_pkg::*;
#(
	parameter int unsigned MaxBins = MAX_BINS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [POW_W-1:0]     bin_power,
	input  logic                 last_bin,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [FREQ_W-1:0]    frequency_q4,
	output logic [FUND_W-1:0]    fundamental_bin_q3,
	output logic [OT_W-1:0]      overtone_count,
	output logic                 noise_too_high,
	output logic                 note_found
);

	sfp_cmd_t    cmd;
	sfp_status_t status;

	assign cfg_ready = 1'b1;

	sfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	sfp_datapath #(
		.MaxBins (MaxBins)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.bin_power          (bin_power),
		.last_bin           (last_bin),
		.cmd                (cmd),
		.status             (status),
		.frequency_q4       (frequency_q4),
		.fundamental_bin_q3 (fundamental_bin_q3),
		.overtone_count     (overtone_count),
		.noise_too_high     (noise_too_high),
		.note_found         (note_found)
	);

endmodule

// ===== src/sfp_ctrl.sv =====
// Controller of the spectral fundamental picker: sequencing state machine, division
// step counter and output valid. Depends on sfp_pkg.
`timescale 1ns / 1ps

module sfp_ctrl
	import sfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	input  sfp_status_t status,
	output sfp_cmd_t    cmd
);

	typedef enum logic [5:0] {
		ST_RUN  = 6'b000001,
		ST_TOL  = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_CMP  = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t               state_q;
	state_t               state_next;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;
	logic                 out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_RUN);
	assign out_valid = out_valid_q;

	assign cmd.accept   = (state_q == ST_RUN) && in_valid;
	assign cmd.tol_load = (state_q == ST_TOL);
	assign cmd.fin_mul  = (state_q == ST_MUL);
	assign cmd.fin_cmp  = (state_q == ST_CMP);
	assign cmd.div_step = (state_q == ST_DIV);
	assign cmd.out_load = (state_q == ST_DONE) && out_free;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_RUN: begin
				if (in_valid) begin
					if (status.last) begin
						state_next = ST_MUL;
					end else if (status.fund_change) begin
						state_next = ST_TOL;
					end
				end
			end
			ST_TOL:  state_next = ST_RUN;
			ST_MUL:  state_next = ST_CMP;
			ST_CMP:  state_next = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_next = ST_RUN;
				end
			end
			default: state_next = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.fin_cmp) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/sfp_datapath.sv =====
// Datapath of the spectral fundamental picker: configuration registers, peak and
// overtone logic, noise sum, final multiplies, bit-serial divider and result register.
// Depends on sfp_pkg.
`timescale 1ns / 1ps

module sfp_datapath
	import sfp_pkg::*;
#(
	parameter int unsigned MaxBins = MAX_BINS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic [POW_W-1:0]     bin_power,
	input  logic                 last_bin,
	input  sfp_cmd_t             cmd,
	output sfp_status_t          status,
	output logic [FREQ_W-1:0]    frequency_q4,
	output logic [FUND_W-1:0]    fundamental_bin_q3,
	output logic [OT_W-1:0]      overtone_count,
	output logic                 noise_too_high,
	output logic                 note_found
);

	localparam int MaxBinsW = $clog2(MaxBins + 1);
	localparam int CmpW     = (MaxBinsW > BIN_W) ? MaxBinsW : BIN_W;

	logic [BIN_W-1:0]   bin_count_q;
	logic [RATE_W-1:0]  sample_rate_q;
	logic [POW_W-1:0]   peak_thr_q;
	logic [POW_W-1:0]   noise_thr_q;

	logic [POW_W-1:0]   older_q;
	logic [POW_W-1:0]   newer_q;
	logic [BIN_W-1:0]   bin_idx_q;
	logic [FUND_W-1:0]  fund_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [OT_W-1:0]    ot_q;
	logic [NOISE_W-1:0] noise_q;
	logic [TOL_W-1:0]   tol_q;

	logic [PROD_W-1:0]  prod_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               noisy_q;
	logic               found_q;
	logic [PROD_W-1:0]  num_q;
	logic [PROD_W-1:0]  quo_q;
	logic [BIN_W-1:0]   rem_q;

	logic [FREQ_W-1:0]  freq_out_q;
	logic [FUND_W-1:0]  fund_out_q;
	logic [OT_W-1:0]    ot_out_q;
	logic               noisy_out_q;
	logic               found_out_q;

	logic [BIN_W-1:0]            eff_bins;
	logic                        judge_en;
	logic [BIN_W-1:0]            judge_idx;
	logic [FUND_W-1:0]           pos;
	logic                        is_peak;
	logic [SCALED_W-1:0]         scaled;
	logic [SCALED_W-1:0]         diff;
	logic                        near;
	logic                        take_first;
	logic                        take_refine;
	logic                        noise_en;
	logic [NOISE_W:0]            noise_add;
	logic [NOISE_W-1:0]          noise_next;
	logic [FUND_W+RECIP_W-1:0]   tol_prod;
	logic [TOL_W-1:0]            tol_div;
	logic [BIN_W:0]              rem_shift;
	logic                        rem_ge;
	logic [FREQ_W-1:0]           freq_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q   <= BIN_COUNT_RESET;
			sample_rate_q <= SAMPLE_RATE_RESET;
			peak_thr_q    <= PEAK_THR_RESET;
			noise_thr_q   <= NOISE_THR_RESET;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BIN_COUNT:   bin_count_q   <= cfg_data[BIN_W-1:0];
				CFG_SAMPLE_RATE: sample_rate_q <= cfg_data[RATE_W-1:0];
				CFG_PEAK_THR:    peak_thr_q    <= cfg_data[POW_W-1:0];
				CFG_NOISE_THR:   noise_thr_q   <= cfg_data[POW_W-1:0];
				default: ;
			endcase
		end
	end

	assign eff_bins = (CmpW'(bin_count_q) > CmpW'(MaxBins)) ? BIN_W'(MaxBins) : bin_count_q;

	// Bin index minus one is judged; it must lie between one and the bin count minus one.
	assign judge_en  = (bin_idx_q >= BIN_W'(2)) && (bin_idx_q <= eff_bins);
	assign judge_idx = bin_idx_q - 1'b1;
	assign pos       = {judge_idx, 3'b000};
	assign is_peak   = (newer_q > peak_thr_q) && (newer_q > older_q) && (newer_q > bin_power);

	assign scaled = SCALED_W'(fund_q) << shift_q;
	assign diff   = (scaled > SCALED_W'(pos)) ? (scaled - SCALED_W'(pos))
	                                          : (SCALED_W'(pos) - scaled);
	assign near   = diff < SCALED_W'(tol_q);

	assign take_first  = judge_en && is_peak && (fund_q == '0);
	assign take_refine = judge_en && is_peak && (fund_q != '0) && (ot_q < OT_MAX) && near;

	assign noise_en   = judge_en && ({judge_idx, 1'b0} > {1'b0, eff_bins});
	assign noise_add  = {1'b0, noise_q} + (NOISE_W + 1)'(newer_q);
	assign noise_next = noise_add[NOISE_W] ? {NOISE_W{1'b1}} : noise_add[NOISE_W-1:0];

	assign status.fund_change = take_first || take_refine;
	assign status.last        = last_bin;

	// The tolerance is a fifth of the fundamental, by multiplication with a reciprocal.
	assign tol_prod = (FUND_W + RECIP_W)'(fund_q) * (FUND_W + RECIP_W)'(DIV5_RECIP);
	assign tol_div  = tol_prod[DIV5_SHIFT +: TOL_W];

	assign rem_shift = {rem_q, num_q[PROD_W-1]};
	assign rem_ge    = rem_shift >= {1'b0, eff_bins};

	assign freq_sat = (|quo_q[PROD_W-1:FREQ_W]) ? {FREQ_W{1'b1}} : quo_q[FREQ_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q   <= '0;
			newer_q   <= '0;
			bin_idx_q <= '0;
			fund_q    <= '0;
			shift_q   <= SHIFT_RESET;
			ot_q      <= '0;
			noise_q   <= '0;
		end else if (cmd.out_load) begin
			older_q   <= '0;
			newer_q   <= '0;
			bin_idx_q <= '0;
			fund_q    <= '0;
			shift_q   <= SHIFT_RESET;
			ot_q      <= '0;
			noise_q   <= '0;
		end else if (cmd.accept) begin
			older_q <= newer_q;
			newer_q <= bin_power;
			if (bin_idx_q != {BIN_W{1'b1}}) begin
				bin_idx_q <= bin_idx_q + 1'b1;
			end
			if (take_first) begin
				fund_q <= pos;
			end else if (take_refine) begin
				fund_q  <= pos >> shift_q;
				shift_q <= shift_q + 1'b1;
				ot_q    <= ot_q + 1'b1;
			end
			if (noise_en) begin
				noise_q <= noise_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tol_load) begin
			tol_q <= (tol_div < TOL_MIN) ? TOL_MIN : tol_div;
		end
		if (cmd.fin_mul) begin
			prod_q  <= PROD_W'(sample_rate_q) * PROD_W'(fund_q);
			limit_q <= LIMIT_W'(noise_thr_q) * LIMIT_W'(eff_bins);
		end
		if (cmd.fin_cmp) begin
			noisy_q <= LIMIT_W'(noise_q) > limit_q;
			found_q <= !(LIMIT_W'(noise_q) > limit_q) && (ot_q != '0) && (eff_bins != '0);
			num_q   <= prod_q;
			quo_q   <= '0;
			rem_q   <= '0;
		end else if (cmd.div_step) begin
			num_q <= num_q << 1;
			quo_q <= {quo_q[PROD_W-2:0], rem_ge};
			rem_q <= rem_ge ? BIN_W'(rem_shift - {1'b0, eff_bins}) : rem_shift[BIN_W-1:0];
		end
		if (cmd.out_load) begin
			freq_out_q  <= found_q ? freq_sat : '0;
			fund_out_q  <= fund_q;
			ot_out_q    <= ot_q;
			noisy_out_q <= noisy_q;
			found_out_q <= found_q;
		end
	end

	assign frequency_q4       = freq_out_q;
	assign fundamental_bin_q3 = fund_out_q;
	assign overtone_count     = ot_out_q;
	assign noise_too_high     = noisy_out_q;
	assign note_found         = found_out_q;

endmodule

// ===== src/sfp_checker.sv =====
// Port-level checker of the spectral fundamental picker and its bind to the top level.
// Depends on sfp_pkg and spectral_fundamental_picker_assert.svh.
`timescale 1ns / 1ps
`include "spectral_fundamental_picker_assert.svh"

module sfp_checker
	import sfp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              last_bin,
	input logic              out_valid,
	input logic              out_stall,
	input logic [FREQ_W-1:0] frequency_q4,
	input logic [FUND_W-1:0] fundamental_bin_q3,
	input logic [OT_W-1:0]   overtone_count,
	input logic              noise_too_high,
	input logic              note_found
);

	`SFP_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(frequency_q4) && $stable(fundamental_bin_q3), "Stalled result transaction changed.")
	`SFP_ASSERT_IMP(a_found_clean, clk, arst_n, out_valid && note_found, !noise_too_high && (overtone_count != '0) && (fundamental_bin_q3 != '0), "Note reported without a clean fundamental.")
	`SFP_ASSERT_IMP(a_reject_zero, clk, arst_n, out_valid && !note_found, frequency_q4 == '0, "Rejected result carries a frequency.")
	`SFP_ASSERT_NXT(a_last_busy, clk, arst_n, in_valid && !in_stall && last_bin, in_stall, "Input taken right after the last bin.")

endmodule

bind spectral_fundamental_picker sfp_checker u_sfp_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_valid),
	.in_stall           (in_stall),
	.last_bin           (last_bin),
	.out_valid          (out_valid),
	.out_stall          (out_stall),
	.frequency_q4       (frequency_q4),
	.fundamental_bin_q3 (fundamental_bin_q3),
	.overtone_count     (overtone_count),
	.noise_too_high     (noise_too_high),
	.note_found         (note_found)
);
